### rtl/slrc_pkg.sv
// Shared types and constants for the STX/ETX LRC deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package slrc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_STATION_ID       = 2'd0;
    localparam logic [1:0] REG_START_CODE       = 2'd1;
    localparam logic [1:0] REG_END_CODE         = 2'd2;
    localparam logic [1:0] REG_ACCEPT_BROADCAST = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_STATION_ID       = 8'h01;
    localparam logic [7:0] RST_START_CODE       = 8'h02;
    localparam logic [7:0] RST_END_CODE         = 8'h03;
    localparam logic       RST_ACCEPT_BROADCAST = 1'b1;

    localparam logic [7:0] BCAST_ID = 8'hFF;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD     = 3'd0;
    localparam logic [2:0] KIND_FOR_US      = 3'd1;
    localparam logic [2:0] KIND_FOR_OTHER   = 3'd2;
    localparam logic [2:0] KIND_CHECK_BAD   = 3'd3;
    localparam logic [2:0] KIND_END_MISSING = 3'd4;

    typedef struct packed {
        logic [7:0] station_id;
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic       accept_broadcast;
    } cfg_t;

    typedef enum logic [6:0] {
        PH_HUNT  = 7'b0000001,
        PH_ID    = 7'b0000010,
        PH_OPC   = 7'b0000100,
        PH_LENH  = 7'b0001000,
        PH_LENL  = 7'b0010000,
        PH_BODY  = 7'b0100000,
        PH_TAIL  = 7'b1000000
    } phase_t;

endpackage

`default_nettype wire

### rtl/slrc_cfg_regs.sv
// Configuration register bank of the deframer.
// Depends on slrc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module slrc_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_wr_index,
    input  wire logic [7:0]    cfg_wr_data,
    output slrc_pkg::cfg_t     cfg
);
    import slrc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.station_id       <= RST_STATION_ID;
            cfg_reg.start_code       <= RST_START_CODE;
            cfg_reg.end_code         <= RST_END_CODE;
            cfg_reg.accept_broadcast <= RST_ACCEPT_BROADCAST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_STATION_ID:       cfg_reg.station_id       <= cfg_wr_data;
                REG_START_CODE:       cfg_reg.start_code       <= cfg_wr_data;
                REG_END_CODE:         cfg_reg.end_code         <= cfg_wr_data;
                REG_ACCEPT_BROADCAST: cfg_reg.accept_broadcast <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/slrc_parser.sv
// Frame parser state machine with the result register.
// Depends on slrc_pkg for phase_t, cfg_t and result kind codes.
`default_nettype none

module slrc_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire slrc_pkg::cfg_t cfg,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    byte_data,
    output logic               byte_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_kind,
    output logic [7:0]         m_payload_byte,
    output logic [7:0]         m_frame_station,
    output logic [7:0]         m_frame_opcode,
    output logic [15:0]        m_frame_length,
    output logic               m_frame_end
);
    import slrc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  station_reg, station_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  check_reg, check_next;

    logic        res_fire;
    logic [2:0]  res_kind;
    logic [7:0]  res_byte;
    logic        ours;
    logic        advance;

    logic        m_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  pbyte_reg;
    logic [7:0]  ostation_reg;
    logic [7:0]  oopcode_reg;
    logic [15:0] olength_reg;
    logic        oend_reg;

    // Take a byte whenever the result register is free or being drained
    assign byte_ready = !m_valid_reg || m_ready;
    assign advance    = byte_valid && byte_ready;

    assign ours = (station_reg == cfg.station_id) ||
                  (cfg.accept_broadcast && (station_reg == BCAST_ID));

    always_comb begin
        phase_next   = phase_reg;
        xor_next     = xor_reg;
        station_next = station_reg;
        opcode_next  = opcode_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        check_next   = check_reg;
        res_fire     = 1'b0;
        res_kind     = KIND_PAYLOAD;
        res_byte     = 8'h00;
        unique case (phase_reg)
            PH_HUNT: begin
                if (byte_data == cfg.start_code) begin
                    phase_next  = PH_ID;
                    opcode_next = 8'h00;
                    length_next = 16'h0000;
                    count_next  = 16'h0000;
                    xor_next    = 8'h00;
                end
            end
            PH_ID: begin
                station_next = byte_data;
                xor_next     = byte_data;
                phase_next   = PH_OPC;
            end
            PH_OPC: begin
                opcode_next = byte_data;
                xor_next    = xor_reg ^ byte_data;
                phase_next  = PH_LENH;
            end
            PH_LENH: begin
                length_next = {byte_data, 8'h00};
                xor_next    = xor_reg ^ byte_data;
                phase_next  = PH_LENL;
            end
            PH_LENL: begin
                length_next = {length_reg[15:8], byte_data};
                xor_next    = xor_reg ^ byte_data;
                phase_next  = PH_BODY;
            end
            PH_BODY: begin
                if (count_reg < length_reg) begin
                    xor_next   = xor_reg ^ byte_data;
                    count_next = count_reg + 16'd1;
                    res_fire   = 1'b1;
                    res_kind   = KIND_PAYLOAD;
                    res_byte   = byte_data;
                end else begin
                    check_next = byte_data;
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                phase_next = PH_HUNT;
                res_fire   = 1'b1;
                priority if (byte_data != cfg.end_code) begin
                    res_kind = KIND_END_MISSING;
                end else if (check_reg != xor_reg) begin
                    res_kind = KIND_CHECK_BAD;
                end else if (ours) begin
                    res_kind = KIND_FOR_US;
                end else begin
                    res_kind = KIND_FOR_OTHER;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            xor_reg     <= 8'h00;
            station_reg <= 8'h00;
            opcode_reg  <= 8'h00;
            length_reg  <= 16'h0000;
            count_reg   <= 16'h0000;
            check_reg   <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg   <= phase_next;
                xor_reg     <= xor_next;
                station_reg <= station_next;
                opcode_reg  <= opcode_next;
                length_reg  <= length_next;
                count_reg   <= count_next;
                check_reg   <= check_next;
            end
            if (advance && res_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load with each produced result
    always_ff @(posedge aclk) begin
        if (advance && res_fire) begin
            kind_reg     <= res_kind;
            pbyte_reg    <= res_byte;
            ostation_reg <= station_next;
            oopcode_reg  <= opcode_next;
            olength_reg  <= length_next;
            oend_reg     <= (res_kind != KIND_PAYLOAD);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_payload_byte  = pbyte_reg;
    assign m_frame_station = ostation_reg;
    assign m_frame_opcode  = oopcode_reg;
    assign m_frame_length  = olength_reg;
    assign m_frame_end     = oend_reg;

endmodule

`default_nettype wire

### rtl/stx_etx_lrc_deframer_top.sv
// Top level of the STX/ETX frame deframer with XOR LRC check.
// Depends on slrc_pkg, slrc_cfg_regs and slrc_parser.
`default_nettype none

//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_rx_byte
//  m_        out        m_valid/m_ready    m_kind, m_payload_byte, m_frame_station,
//                                          m_frame_opcode, m_frame_length, m_frame_end
//  cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
//  One byte per cycle sustained while m_ready stays high: a request is held in
//  the input register, then the parser updates its state and loads the result
//  register. A result is valid once it sits in the result register and can
//  leave at the following edge.
//  aresetn is synchronous, active low; it clears the parser, both valid flags
//  and restores the configuration defaults.
//  A stall on m_ready holds the result register and backs up into the input
//  register; s_ready drops only when both are full.

module stx_etx_lrc_deframer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_payload_byte,
    output logic [7:0]       m_frame_station,
    output logic [7:0]       m_frame_opcode,
    output logic [15:0]      m_frame_length,
    output logic             m_frame_end,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [7:0]  cfg_wr_data
);
    import slrc_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       parse_ready;

    slrc_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Input register: accept a new request when empty or when the parser
    // takes the held byte this cycle.
    assign s_ready = !in_valid_reg || parse_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    slrc_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .byte_valid      (in_valid_reg),
        .byte_data       (in_byte_reg),
        .byte_ready      (parse_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_frame_station (m_frame_station),
        .m_frame_opcode  (m_frame_opcode),
        .m_frame_length  (m_frame_length),
        .m_frame_end     (m_frame_end)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for stx_etx_lrc_deframer_top: feeds received bytes,
// predicts payload and frame status results, compares them as they come out.
// Depends on slrc_pkg and the deframer RTL.

module tb_top;
    import slrc_pkg::*;

    // Slowest correct run: about 500 requests, each with the longest idle gap on
    // the send side and a stall on the result side, plus drains and register
    // writes. TIMEOUT_NS leaves a wide margin over that.
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DRAIN_CYCLES = 8;     // pipeline is two deep
    localparam int RANDOM_ITEMS = 60;
    localparam int MAX_REPORTS  = 10;

    // One result as it leaves the block, in port order.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  station;
        logic [7:0]  opcode;
        logic [15:0] length;
        logic        frame_end;
    } deframe_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic [7:0]  s_rx_byte    = 8'h00;
    logic        m_ready      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_wr_index = REG_STATION_ID;
    logic [7:0]  cfg_wr_data  = 8'h00;

    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_frame_station;
    logic [7:0]  m_frame_opcode;
    logic [15:0] m_frame_length;
    logic        m_frame_end;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    stx_etx_lrc_deframer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_frame_station (m_frame_station),
        .m_frame_opcode  (m_frame_opcode),
        .m_frame_length  (m_frame_length),
        .m_frame_end     (m_frame_end),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Deframer prediction: own copy of registers and parser state
    // ------------------------------------------------------------------
    cfg_t        cur_cfg = '{RST_STATION_ID, RST_START_CODE, RST_END_CODE,
                             RST_ACCEPT_BROADCAST};
    phase_t      p_phase   = PH_HUNT;
    logic [7:0]  p_xor     = 8'h00;
    logic [7:0]  p_station = 8'h00;
    logic [7:0]  p_opcode  = 8'h00;
    logic [15:0] p_length  = 16'h0000;
    logic [15:0] p_count   = 16'h0000;
    logic [7:0]  p_check   = 8'h00;

    deframe_result_t pending_results[$];

    // Run bookkeeping
    int unsigned failures        = 0;
    int unsigned results_checked = 0;
    int unsigned frames_sent     = 0;
    int unsigned framed_bytes    = 0;
    int unsigned settings_used   = 1;
    int unsigned input_stalls    = 0;

    // Idling control shared by the sender and the receiver
    bit          steady_mode   = 1'b0;  // set: no idling on either side
    int unsigned stall_request = 0;     // receiver holds off this many cycles

    // Advance the parser by one accepted byte; queue the result it causes.
    task automatic deframe_byte(input logic [7:0] b);
        deframe_result_t r;
        bit              has_result;
        logic            ours;
        r          = '0;
        has_result = 1'b0;
        case (p_phase)
            PH_HUNT: if (b == cur_cfg.start_code) begin
                // open a frame; the held station waits for the id byte
                p_phase  = PH_ID;
                p_opcode = 8'h00;
                p_length = 16'h0000;
                p_count  = 16'h0000;
                p_xor    = 8'h00;
            end
            PH_ID: begin
                p_station = b;
                p_xor     = b;
                p_phase   = PH_OPC;
            end
            PH_OPC: begin
                p_opcode = b;
                p_xor    = p_xor ^ b;
                p_phase  = PH_LENH;
            end
            PH_LENH: begin
                p_length = {b, 8'h00};
                p_xor    = p_xor ^ b;
                p_phase  = PH_LENL;
            end
            PH_LENL: begin
                p_length[7:0] = b;
                p_xor         = p_xor ^ b;
                p_phase       = PH_BODY;
            end
            PH_BODY: if (p_count < p_length) begin
                p_xor          = p_xor ^ b;
                p_count        = p_count + 16'd1;
                has_result     = 1'b1;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
            end else begin
                p_check = b;
                p_phase = PH_TAIL;
            end
            PH_TAIL: begin
                // wrong end byte wins over a bad check; neither reopens a frame
                p_phase     = PH_HUNT;
                has_result  = 1'b1;
                r.frame_end = 1'b1;
                if (b != cur_cfg.end_code) begin
                    r.kind = KIND_END_MISSING;
                end else if (p_check != p_xor) begin
                    r.kind = KIND_CHECK_BAD;
                end else begin
                    ours   = (p_station == cur_cfg.station_id) ||
                             (cur_cfg.accept_broadcast && p_station == BCAST_ID);
                    r.kind = ours ? KIND_FOR_US : KIND_FOR_OTHER;
                end
            end
            default: p_phase = PH_HUNT;
        endcase
        if (has_result) begin
            r.station = p_station;
            r.opcode  = p_opcode;
            r.length  = p_length;
            pending_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Helpers shared by the tests
    // ------------------------------------------------------------------
    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] other_station();
        logic [7:0] id;
        do id = 8'($urandom);
        while (id == cur_cfg.station_id || id == BCAST_ID);
        return id;
    endfunction

    // Field value biased toward the extremes.
    function automatic logic [7:0] pick_code();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Offer one request, hold it until accepted, then maybe idle.
    task automatic send_byte(input logic [7:0] value);
        int unsigned waits;
        int unsigned gap_len;
        waits     = 0;
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        @(posedge aclk);
        while (!s_ready) begin
            waits++;
            @(posedge aclk);
        end
        if (waits != 0) input_stalls++;
        deframe_byte(value);
        gap_len = steady_mode ? 0 : idle_length();
        if (gap_len != 0) begin
            s_valid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
    endtask

    // Send a whole frame. A nonzero check_flip corrupts the check byte;
    // end_byte and fill override the end byte and payload when not negative.
    task automatic send_frame(input logic [7:0]  station,
                              input logic [7:0]  opcode,
                              input logic [15:0] len,
                              input logic [7:0]  check_flip = 8'h00,
                              input int          end_byte = -1,
                              input int          fill = -1);
        logic [7:0] lrc;
        logic [7:0] data_byte;
        lrc = station ^ opcode ^ len[15:8] ^ len[7:0];
        send_byte(cur_cfg.start_code);
        send_byte(station);
        send_byte(opcode);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i < int'(len); i++) begin
            data_byte = (fill < 0) ? 8'($urandom) : fill[7:0];
            lrc       = lrc ^ data_byte;
            send_byte(data_byte);
        end
        send_byte(lrc ^ check_flip);
        send_byte((end_byte < 0) ? cur_cfg.end_code : end_byte[7:0]);
        frames_sent++;
        framed_bytes += int'(len) + 7;
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (index)
            REG_STATION_ID:       cur_cfg.station_id       = data;
            REG_START_CODE:       cur_cfg.start_code       = data;
            REG_END_CODE:         cur_cfg.end_code         = data;
            REG_ACCEPT_BROADCAST: cur_cfg.accept_broadcast = data[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Only call with the block drained.
    task automatic program_registers(input logic [7:0] station,
                                     input logic [7:0] start_byte,
                                     input logic [7:0] stop_byte,
                                     input logic       broadcast);
        write_reg(REG_STATION_ID, station);
        write_reg(REG_START_CODE, start_byte);
        write_reg(REG_END_CODE, stop_byte);
        write_reg(REG_ACCEPT_BROADCAST, {7'b0, broadcast});
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset register values: hunting noise, a zero-length broadcast frame,
    // a wrong end byte equal to the start code, and a bad check.
    task automatic test_frame_outcomes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(BCAST_ID, 8'h00, 16'd0);
        send_frame(RST_STATION_ID, 8'hFF, 16'd2, 8'h00, RST_START_CODE, 8'hFF);
        send_frame(8'h00, 8'h00, 16'd1, 8'h80, -1, 8'h00);
        drain_results();
    endtask

    // Own, broadcast and foreign frames under extreme, fixed and random registers.
    task automatic test_register_settings();
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: program_registers(8'h00, 8'h00, 8'hFF, 1'b0);
                1: program_registers(8'hFF, 8'hFF, 8'h00, 1'b0);
                2: program_registers(8'h5A, 8'hA5, 8'hA5, 1'b1);
                default: program_registers(8'($urandom), 8'($urandom), 8'($urandom),
                                           1'b1);
            endcase
            send_frame(cur_cfg.station_id, 8'($urandom), 16'($urandom_range(0, 3)));
            send_frame(BCAST_ID, 8'($urandom), 16'($urandom_range(0, 3)));
            send_frame(other_station(), 8'($urandom), 16'd1);
            drain_results();
        end
    endtask

    // Declared length with a nonzero high byte, run without idling.
    task automatic test_long_frame();
        steady_mode = 1'b1;
        send_frame(cur_cfg.station_id, 8'h81, 16'h0100);
        drain_results();
        steady_mode = 1'b0;
    endtask

    // Hold the result side off while requests keep coming, so the block
    // fills both stages and drops s_ready.
    task automatic test_input_backpressure();
        steady_mode   = 1'b1;
        stall_request = 60;
        send_frame(cur_cfg.station_id, 8'hC3, 16'd40);
        drain_results();
        steady_mode = 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest carry a bad
    // check or a wrong end byte, and some follow hunting noise. Registers
    // change between batches once the block is drained.
    task automatic test_random_traffic();
        int unsigned first_byte;
        int unsigned roll;
        logic [7:0]  station;
        logic [15:0] len;
        logic [7:0]  flip;
        int          stop;
        first_byte = framed_bytes;
        while (framed_bytes - first_byte < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                drain_results();
                program_registers(pick_code(), pick_code(), pick_code(),
                                  1'($urandom_range(0, 1)));
                steady_mode = ($urandom_range(0, 4) == 0);
            end
            roll = $urandom_range(0, 9);
            if (roll < 4) station = cur_cfg.station_id;
            else if (roll < 6) station = BCAST_ID;
            else station = 8'($urandom);
            len  = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(9, 48))
                                               : 16'($urandom_range(0, 8));
            flip = 8'h00;
            stop = -1;
            roll = $urandom_range(0, 19);
            if (roll < 3) flip = 8'($urandom_range(1, 255));
            else if (roll < 6) stop = int'(cur_cfg.end_code ^ 8'($urandom_range(1, 255)));
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(cur_cfg.start_code ^
                                                        8'($urandom_range(1, 255)));
            end
            send_frame(station, 8'($urandom), len, flip, stop);
        end
        steady_mode = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned run_len;
        int unsigned gap_len;
        forever begin
            if (stall_request != 0) begin
                gap_len       = stall_request;
                stall_request = 0;
                m_ready <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end else if (steady_mode) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                run_len = $urandom_range(1, 16);
                gap_len = idle_length();
                m_ready <= 1'b1;
                repeat (run_len) @(posedge aclk);
                if (gap_len != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap_len) @(posedge aclk);
                end
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        deframe_result_t want;
        deframe_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_kind, m_payload_byte, m_frame_station, m_frame_opcode,
                    m_frame_length, m_frame_end};
            results_checked++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result kind %0d byte %02h stn %02h",
                                       got.kind, got.payload_byte, got.station));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    note_failure($sformatf({"result %0d: exp kind %0d byte %02h stn %02h",
                        " opc %02h len %04h end %0b, got kind %0d byte %02h stn %02h",
                        " opc %02h len %04h end %0b"}, results_checked,
                        want.kind, want.payload_byte, want.station, want.opcode,
                        want.length, want.frame_end, got.kind, got.payload_byte,
                        got.station, got.opcode, got.length, got.frame_end));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        // hold reset, then release it on a clock edge
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_frame_outcomes();
        test_register_settings();
        test_long_frame();
        test_input_backpressure();
        test_random_traffic();

        drain_results();
        $display("Sent %0d frames (%0d framed bytes) under %0d register settings.",
                 frames_sent, framed_bytes, settings_used);
        $display("Checked %0d results, input held off %0d times, %0d failures.",
                 results_checked, input_stalls, failures + pending_results.size());
        if (failures == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
